// ===== rtl/core/cmcb_pkg.sv =====
// Shared types and constants for the circle/box contact manifold core.
// No dependencies; imported by every module of the core.
package cmcb_pkg;

  localparam int PW     = 32;  // position width, Q16.16
  localparam int SW     = 31;  // size/radius width, Q16.16
  localparam int GW     = 34;  // exact edge/delta width
  localparam int MW     = 33;  // delta magnitude width
  localparam int DSQ_W  = 64;  // squared distance kept for hits
  localparam int SQ_N   = 46;  // root bits, one per sqrt stage
  localparam int RW     = 48;  // sqrt partial remainder width
  localparam int FRAC_SH = 28; // extra radicand scaling, 2^28
  localparam int NUM_W  = 63;  // dividend width for the normal divide
  localparam int DV_N   = 16;  // quotient bits, one per divide stage
  localparam int QD     = 4;   // front/back queue depth
  localparam int QAW    = 2;   // queue pointer width

  localparam logic signed [15:0] ONE_Q14  = 16'sd16384;
  localparam logic signed [15:0] MONE_Q14 = -16'sd16384;
  localparam logic [31:0]        DEPTH_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [PW-1:0] a_pos_x;
    logic signed [PW-1:0] a_pos_y;
    logic [SW-1:0]        a_width;
    logic [SW-1:0]        a_height;
    logic [SW-1:0]        a_radius;
    logic                 a_round;
    logic signed [PW-1:0] b_pos_x;
    logic signed [PW-1:0] b_pos_y;
    logic [SW-1:0]        b_width;
    logic [SW-1:0]        b_height;
    logic [SW-1:0]        b_radius;
    logic                 b_round;
  } pair_t;

  // Classified pair handed from front to back
  typedef struct packed {
    logic                 use_root; // normal/depth need sqrt and divide
    logic                 hit;
    logic                 neg;      // box-then-circle: negate normal
    logic                 sx;
    logic                 sy;
    logic [MW-1:0]        mdx;
    logic [MW-1:0]        mdy;
    logic [DSQ_W-1:0]     dsq;
    logic [31:0]          rad;
    logic signed [15:0]   nx;       // used when use_root is low
    logic signed [15:0]   ny;
    logic [31:0]          dep;
  } rec_t;

endpackage

// ===== rtl/core/cmcb_front.sv =====
// Front end: geometry, squared distances and classification of one pair.
// Four-stage pipeline with a common enable; uses cmcb_pkg.
module cmcb_front
  import cmcb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  pair_t in_pair,
  output logic  rec_valid,
  output rec_t  rec_o
);

  // ---------------- stage 1: edges and combined radius
  logic [3:0] v_r;
  logic signed [GW-1:0] ax_r, ay_r, bx_r, by_r, ax2_r, ay2_r, bx2_r, by2_r;
  logic [31:0] rad1_r;
  logic ar_r, br_r;

  logic signed [GW-1:0] ax_s, ay_s, bx_s, by_s, bw_s, bh_s;
  logic [31:0] rad_s;

  always_comb begin
    ax_s = GW'(in_pair.a_pos_x);
    ay_s = GW'(in_pair.a_pos_y);
    bx_s = GW'(in_pair.b_pos_x);
    by_s = GW'(in_pair.b_pos_y);
    // circle/circle: B becomes a point box, so one clamp serves both cases
    bw_s = (in_pair.a_round & in_pair.b_round) ? '0 : $signed({3'b000, in_pair.b_width});
    bh_s = (in_pair.a_round & in_pair.b_round) ? '0 : $signed({3'b000, in_pair.b_height});
    if (in_pair.a_round) begin
      rad_s = 32'(in_pair.a_radius) + (in_pair.b_round ? 32'(in_pair.b_radius) : 32'd0);
    end else begin
      rad_s = 32'(in_pair.b_radius);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= ax_s;
      ay_r   <= ay_s;
      bx_r   <= bx_s;
      by_r   <= by_s;
      ax2_r  <= ax_s + $signed({3'b000, in_pair.a_width});
      ay2_r  <= ay_s + $signed({3'b000, in_pair.a_height});
      bx2_r  <= bx_s + bw_s;
      by2_r  <= by_s + bh_s;
      rad1_r <= rad_s;
      ar_r   <= in_pair.a_round;
      br_r   <= in_pair.b_round;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // ---------------- stage 2: closest point, face distances, box overlap
  logic signed [GW-1:0] cx, cy, lox, hix, loy, hiy, px, py;
  logic signed [GW-1:0] dx2_r, dy2_r, dl_r, dr_r, dt_r, db_r, ox_r, oy_r;
  logic [31:0] rad2_r;
  logic cxlt_r, cylt_r, bb2_r, hbb2_r, neg2_r;
  logic sep;

  always_comb begin
    cx  = ar_r ? ax_r  : bx_r;
    cy  = ar_r ? ay_r  : by_r;
    lox = ar_r ? bx_r  : ax_r;
    hix = ar_r ? bx2_r : ax2_r;
    loy = ar_r ? by_r  : ay_r;
    hiy = ar_r ? by2_r : ay2_r;
    px  = (cx < lox) ? lox : ((cx > hix) ? hix : cx);
    py  = (cy < loy) ? loy : ((cy > hiy) ? hiy : cy);
    sep = (ax2_r <= bx_r) | (bx2_r <= ax_r) | (ay2_r <= by_r) | (by2_r <= ay_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r  <= px - cx;
      dy2_r  <= py - cy;
      dl_r   <= cx - lox;
      dr_r   <= hix - cx;
      dt_r   <= cy - loy;
      db_r   <= hiy - cy;
      ox_r   <= (ax2_r < bx2_r) ? (ax2_r - bx_r) : (bx2_r - ax_r);
      oy_r   <= (ay2_r < by2_r) ? (ay2_r - by_r) : (by2_r - ay_r);
      cxlt_r <= (ax_r + ax2_r) < (bx_r + bx2_r);
      cylt_r <= (ay_r + ay2_r) < (by_r + by2_r);
      rad2_r <= rad1_r;
      bb2_r  <= ~ar_r & ~br_r;
      hbb2_r <= ~ar_r & ~br_r & ~sep;
      neg2_r <= ~ar_r & br_r;
    end
  end

  // ---------------- stage 3: squares, first face round, box axis pick
  logic [MW-1:0] mdx, mdy, mdx3_r, mdy3_r;
  logic [2*MW-1:0] sqx3_r, sqy3_r;
  logic [63:0] rsq3_r;
  logic [31:0] rad3_r, bbdep3_r;
  logic sx3_r, sy3_r, lr3_r, tb3_r, bb3_r, hbb3_r, neg3_r;
  logic signed [GW-1:0] lrb3_r, tbb3_r;
  logic signed [15:0] bbnx3_r, bbny3_r;
  logic use_y;

  always_comb begin
    mdx   = dx2_r[GW-1] ? MW'(-dx2_r) : MW'(dx2_r);
    mdy   = dy2_r[GW-1] ? MW'(-dy2_r) : MW'(dy2_r);
    use_y = ~(ox_r < oy_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mdx3_r   <= mdx;
      mdy3_r   <= mdy;
      sqx3_r   <= (2*MW)'(mdx) * (2*MW)'(mdx);
      sqy3_r   <= (2*MW)'(mdy) * (2*MW)'(mdy);
      rsq3_r   <= 64'(rad2_r) * 64'(rad2_r);
      sx3_r    <= dx2_r[GW-1];
      sy3_r    <= dy2_r[GW-1];
      // ties keep the earlier face: left, right, top, bottom
      lr3_r    <= dr_r < dl_r;
      lrb3_r   <= (dr_r < dl_r) ? dr_r : dl_r;
      tb3_r    <= db_r < dt_r;
      tbb3_r   <= (db_r < dt_r) ? db_r : dt_r;
      rad3_r   <= rad2_r;
      bb3_r    <= bb2_r;
      hbb3_r   <= hbb2_r;
      neg3_r   <= neg2_r;
      bbdep3_r <= use_y ? oy_r[31:0] : ox_r[31:0];
      bbnx3_r  <= use_y ? 16'sd0 : (cxlt_r ? ONE_Q14 : MONE_Q14);
      bbny3_r  <= use_y ? (cylt_r ? ONE_Q14 : MONE_Q14) : 16'sd0;
    end
  end

  // ---------------- stage 4: distance test and classification
  logic [2*MW:0] dsq;
  logic c_hit, zero, pick_tb;
  logic signed [GW-1:0] best;
  logic signed [GW:0] fsum;
  logic [31:0] fdep;
  logic signed [15:0] fnx, fny;
  rec_t rec_s, rec_r;

  always_comb begin
    dsq     = (2*MW+1)'(sqx3_r) + (2*MW+1)'(sqy3_r);
    c_hit   = dsq < (2*MW+1)'(rsq3_r);
    zero    = (dsq == '0);
    pick_tb = tbb3_r < lrb3_r;
    best    = pick_tb ? tbb3_r : lrb3_r;
    fnx     = pick_tb ? 16'sd0 : (lr3_r ? MONE_Q14 : ONE_Q14);
    fny     = pick_tb ? (tb3_r ? MONE_Q14 : ONE_Q14) : 16'sd0;
    fsum    = $signed({3'b000, rad3_r}) + (GW+1)'(best);
    if (fsum[GW]) begin
      fdep = '0;
    end else if (fsum[GW-1:32] != '0) begin
      fdep = DEPTH_MAX;
    end else begin
      fdep = fsum[31:0];
    end

    rec_s          = '0;
    rec_s.neg      = neg3_r;
    rec_s.sx       = sx3_r;
    rec_s.sy       = sy3_r;
    rec_s.mdx      = mdx3_r;
    rec_s.mdy      = mdy3_r;
    rec_s.dsq      = dsq[DSQ_W-1:0];
    rec_s.rad      = rad3_r;
    if (bb3_r) begin
      rec_s.hit = hbb3_r;
      if (hbb3_r) begin
        rec_s.nx  = bbnx3_r;
        rec_s.ny  = bbny3_r;
        rec_s.dep = bbdep3_r;
      end
    end else begin
      rec_s.hit      = c_hit;
      rec_s.use_root = c_hit & ~zero;
      if (c_hit & zero) begin
        rec_s.nx  = fnx;
        rec_s.ny  = fny;
        rec_s.dep = fdep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rec_r <= rec_s;
    end
  end

  assign rec_valid = v_r[3];
  assign rec_o     = rec_r;

endmodule

// ===== rtl/core/cmcb_queue.sv =====
// Short queue of classified pairs between front and back ends.
// Uses rec_t from cmcb_pkg.
module cmcb_queue
  import cmcb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_data,
  input  logic pop,
  output logic full,
  output logic empty,
  output rec_t head
);

  rec_t mem_r [0:QD-1];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QD));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/cmcb_back.sv =====
// Back end: pipelined square root, pipelined normal divide, output register.
// Uses cmcb_pkg; fed from cmcb_queue.
module cmcb_back
  import cmcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rec_t               q_head,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic               out_hit,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic [31:0]        out_depth
);

  logic be;
  logic out_valid_r;

  assign be    = ~out_valid_r | out_pop;
  assign q_pop = be & ~q_empty;

  // ---------------- square root, one root bit per stage
  logic [SQ_N:0]   sq_v_r;
  rec_t            sq_rec_r  [0:SQ_N];
  logic [SQ_N-1:0] sq_root_r [0:SQ_N];
  logic [RW-1:0]   sq_rem_r  [0:SQ_N];
  logic [DSQ_W-1:0] sq_rk_r  [0:SQ_N];

  always_ff @(posedge clk) begin
    if (be) begin
      sq_rec_r[0]  <= q_head;
      sq_root_r[0] <= '0;
      sq_rem_r[0]  <= '0;
      sq_rk_r[0]   <= q_head.dsq;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < SQ_N; gi++) begin : g_sq
      logic [RW+1:0] cat, trial;
      logic ge;
      always_comb begin
        cat   = {sq_rem_r[gi], sq_rk_r[gi][DSQ_W-1 -: 2]};
        trial = {2'b00, sq_root_r[gi], 2'b01};
        ge    = cat >= trial;
      end
      always_ff @(posedge clk) begin
        if (be) begin
          sq_rec_r[gi+1]  <= sq_rec_r[gi];
          sq_root_r[gi+1] <= {sq_root_r[gi][SQ_N-2:0], ge};
          sq_rem_r[gi+1]  <= ge ? RW'(cat - trial) : cat[RW-1:0];
          sq_rk_r[gi+1]   <= {sq_rk_r[gi][DSQ_W-3:0], 2'b00};
        end
      end
    end
  endgenerate

  // ---------------- divide entry: rounded dividends and depth
  logic [SQ_N-1:0] s_fin;
  logic [32:0]     droot;
  rec_t            rec_d0;

  always_comb begin
    s_fin  = sq_root_r[SQ_N];
    droot  = {1'b0, sq_rec_r[SQ_N].rad} - {1'b0, s_fin[SQ_N-1 -: 32]};
    rec_d0 = sq_rec_r[SQ_N];
    if (rec_d0.use_root) begin
      rec_d0.dep = droot[32] ? 32'd0 : droot[31:0];
    end
  end

  logic [DV_N:0]    dv_v_r;
  rec_t             dv_rec_r [0:DV_N];
  logic [SQ_N-1:0]  dv_s_r   [0:DV_N];
  logic [NUM_W-1:0] dv_rx_r  [0:DV_N];
  logic [NUM_W-1:0] dv_ry_r  [0:DV_N];
  logic [DV_N-1:0]  dv_qx_r  [0:DV_N];
  logic [DV_N-1:0]  dv_qy_r  [0:DV_N];

  always_ff @(posedge clk) begin
    if (be) begin
      dv_rec_r[0] <= rec_d0;
      dv_s_r[0]   <= s_fin;
      dv_rx_r[0]  <= NUM_W'({sq_rec_r[SQ_N].mdx, FRAC_SH'(0)}) + NUM_W'(s_fin >> 1);
      dv_ry_r[0]  <= NUM_W'({sq_rec_r[SQ_N].mdy, FRAC_SH'(0)}) + NUM_W'(s_fin >> 1);
      dv_qx_r[0]  <= '0;
      dv_qy_r[0]  <= '0;
    end
  end

  // ---------------- restoring divide, one quotient bit per stage
  generate
    for (gi = 0; gi < DV_N; gi++) begin : g_dv
      logic [NUM_W-1:0] sd;
      logic gx, gy;
      always_comb begin
        sd = NUM_W'(dv_s_r[gi]) << (DV_N - 1 - gi);
        gx = dv_rx_r[gi] >= sd;
        gy = dv_ry_r[gi] >= sd;
      end
      always_ff @(posedge clk) begin
        if (be) begin
          dv_rec_r[gi+1] <= dv_rec_r[gi];
          dv_s_r[gi+1]   <= dv_s_r[gi];
          dv_rx_r[gi+1]  <= gx ? (dv_rx_r[gi] - sd) : dv_rx_r[gi];
          dv_ry_r[gi+1]  <= gy ? (dv_ry_r[gi] - sd) : dv_ry_r[gi];
          dv_qx_r[gi+1]  <= {dv_qx_r[gi][DV_N-2:0], gx};
          dv_qy_r[gi+1]  <= {dv_qy_r[gi][DV_N-2:0], gy};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r      <= '0;
      dv_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (be) begin
      sq_v_r      <= {sq_v_r[SQ_N-1:0], ~q_empty};
      dv_v_r      <= {dv_v_r[DV_N-1:0], sq_v_r[SQ_N]};
      out_valid_r <= dv_v_r[DV_N];
    end
  end

  // ---------------- clamp, sign, swap negation
  rec_t rec_f;
  logic [DV_N-1:0] qcx, qcy;
  logic signed [15:0] vx, vy, fx, fy;
  logic hit_r;
  logic signed [15:0] nx_r, ny_r;
  logic [31:0] dep_r;

  always_comb begin
    rec_f = dv_rec_r[DV_N];
    qcx = (dv_qx_r[DV_N] > DV_N'(ONE_Q14)) ? DV_N'(ONE_Q14) : dv_qx_r[DV_N];
    qcy = (dv_qy_r[DV_N] > DV_N'(ONE_Q14)) ? DV_N'(ONE_Q14) : dv_qy_r[DV_N];
    if (rec_f.use_root) begin
      vx = rec_f.sx ? -$signed(qcx) : $signed(qcx);
      vy = rec_f.sy ? -$signed(qcy) : $signed(qcy);
    end else begin
      vx = rec_f.nx;
      vy = rec_f.ny;
    end
    fx = rec_f.neg ? -vx : vx;
    fy = rec_f.neg ? -vy : vy;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      hit_r <= rec_f.hit;
      nx_r  <= fx;
      ny_r  <= fy;
      dep_r <= rec_f.dep;
    end
  end

  assign out_empty    = ~out_valid_r;
  assign out_hit      = hit_r;
  assign out_normal_x = nx_r;
  assign out_normal_y = ny_r;
  assign out_depth    = dep_r;

endmodule

// ===== rtl/core/contact_manifold_circle_box_core.sv =====
// Top level of the circle/box narrow-phase contact core.
// Depends on cmcb_pkg, cmcb_front, cmcb_queue and cmcb_back.
//
//  channel  ports                          handshake
//  -------  -----------------------------  -------------------------------
//  pair in  in_a_*, in_b_*  (12 fields)     push/full, taken on push & !full
//  contact  out_hit, out_normal_*, depth    empty/pop, taken on pop & !empty
//
// One pair per cycle sustained while results are popped promptly. The path
// runs through four front stages, the queue, one root bit per stage (46), one
// quotient bit per stage (16) and the output register.
// rst_n is synchronous, active low, and clears only valid/pointer state.
// A stalled result freezes the back end; the front keeps taking pairs
// until the queue fills, then raises in_full.
module contact_manifold_circle_box_core
  import cmcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_a_pos_x,
  input  logic signed [31:0] in_a_pos_y,
  input  logic [30:0]        in_a_width,
  input  logic [30:0]        in_a_height,
  input  logic [30:0]        in_a_radius,
  input  logic               in_a_round,
  input  logic signed [31:0] in_b_pos_x,
  input  logic signed [31:0] in_b_pos_y,
  input  logic [30:0]        in_b_width,
  input  logic [30:0]        in_b_height,
  input  logic [30:0]        in_b_radius,
  input  logic               in_b_round,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_hit,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic [31:0]        out_depth
);

  pair_t pair;
  rec_t  f_rec, q_head;
  logic  f_valid, q_full, q_empty, q_pop, f_en;

  always_comb begin
    pair.a_pos_x  = in_a_pos_x;
    pair.a_pos_y  = in_a_pos_y;
    pair.a_width  = in_a_width;
    pair.a_height = in_a_height;
    pair.a_radius = in_a_radius;
    pair.a_round  = in_a_round;
    pair.b_pos_x  = in_b_pos_x;
    pair.b_pos_y  = in_b_pos_y;
    pair.b_width  = in_b_width;
    pair.b_height = in_b_height;
    pair.b_radius = in_b_radius;
    pair.b_round  = in_b_round;
  end

  // front advances only while the queue has room, so nothing is dropped
  assign f_en    = ~q_full;
  assign in_full = ~f_en;

  cmcb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (f_en),
    .in_valid  (in_push),
    .in_pair   (pair),
    .rec_valid (f_valid),
    .rec_o     (f_rec)
  );

  cmcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid & f_en),
    .push_data (f_rec),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  cmcb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_hit      (out_hit),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_depth    (out_depth)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the circle/box narrow-phase contact core.
// Depends on cmcb_pkg and contact_manifold_circle_box_core; needs nothing else.
// Directed table then random pairs, each result checked against a typed answer or the predictor.
`timescale 1ns / 100ps

module tb;
  import cmcb_pkg::*;

  // Expected contact for one pair
  typedef struct packed {
    logic               hit;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [31:0]        dep;
  } contact_t;

  // One row of the directed table; typed rows carry their own answer
  typedef struct {
    pair_t    p;
    bit       typed;
    contact_t e;
  } row_t;

  localparam int N_RANDOM   = 1400;
  localparam int HOLD_LEN   = 400;   // long receiver hold-off, cycles
  localparam int IDLE_LIMIT = 5000;  // watchdog: cycles with no transaction
  localparam int DRAIN_WAIT = 100;   // extra wait after the last expected contact

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [31:0] in_a_pos_x = '0, in_a_pos_y = '0, in_b_pos_x = '0, in_b_pos_y = '0;
  logic [30:0] in_a_width = '0, in_a_height = '0, in_a_radius = '0;
  logic [30:0] in_b_width = '0, in_b_height = '0, in_b_radius = '0;
  logic in_a_round = 1'b0, in_b_round = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_hit;
  logic signed [15:0] out_normal_x, out_normal_y;
  logic [31:0] out_depth;

  contact_t contacts_due[$];   // expected contacts, oldest first
  row_t     dir_rows[$];
  int  mismatches = 0;
  int  pairs_sent = 0, contacts_seen = 0, hits_seen = 0;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;        // sender asks receiver for the long hold-off
  bit  pop_hold = 1'b0;        // receiver is in the hold-off

  contact_manifold_circle_box_core uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- predictor ----------------

  function automatic longint unsigned magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [127:0] dist_sq(longint dx, longint dy);
    logic [127:0] mx, my;
    mx = 128'(magn(dx));
    my = 128'(magn(dy));
    return mx * mx + my * my;
  endfunction

  // floor(sqrt(v * 2^28)), i.e. distance at 2^-30 resolution
  function automatic logic [63:0] root_q30(logic [127:0] v);
    logic [127:0] t, r, c;
    t = v << 28;
    r = '0;
    for (int b = 48; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= t) r = c;
    end
    return r[63:0];
  endfunction

  function automatic logic signed [15:0] unit_q14(longint d, logic [63:0] s);
    longint unsigned q;
    q = ((magn(d) << 28) + s / 2) / s;
    if (q > 16384) q = 16384;
    return d < 0 ? -16'(q) : 16'(q);
  endfunction

  function automatic logic [31:0] clip_depth(longint v);
    if (v < 0) return '0;
    if (v > longint'(DEPTH_MAX)) return DEPTH_MAX;
    return v[31:0];
  endfunction

  // circle (cx,cy,r) against box (rx,ry,rw,rh); normal from circle to box
  function automatic contact_t circle_vs_box(longint cx, longint cy, longint r,
                                             longint rx, longint ry, longint rw, longint rh);
    contact_t c;
    longint rx2, ry2, px, py, dx, dy, best;
    logic [127:0] dsq;
    logic [63:0] s;
    c = '0;
    rx2 = rx + rw;
    ry2 = ry + rh;
    px = cx < rx ? rx : (cx > rx2 ? rx2 : cx);
    py = cy < ry ? ry : (cy > ry2 ? ry2 : cy);
    dx = px - cx;
    dy = py - cy;
    dsq = dist_sq(dx, dy);
    if (dsq >= 128'(r) * 128'(r)) return c;
    c.hit = 1'b1;
    if (dsq != 0) begin
      s = root_q30(dsq);
      c.nx = unit_q14(dx, s);
      c.ny = unit_q14(dy, s);
      c.dep = clip_depth(r - longint'(s >> 14));
      return c;
    end
    // centre inside the box: nearest face, earlier face wins a tie
    best = cx - rx;
    c.nx = ONE_Q14;
    if (rx2 - cx < best) begin best = rx2 - cx; c.nx = MONE_Q14; c.ny = 16'sd0; end
    if (cy - ry < best) begin best = cy - ry; c.nx = 16'sd0; c.ny = ONE_Q14; end
    if (ry2 - cy < best) begin best = ry2 - cy; c.nx = 16'sd0; c.ny = MONE_Q14; end
    c.dep = clip_depth(r + best);
    return c;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint ax, ay, aw, ah, ar, bx, by, bw, bh, br, dx, dy, ox, oy;
    logic [127:0] dsq;
    logic [63:0] s;
    c = '0;
    ax = longint'($signed(p.a_pos_x)); ay = longint'($signed(p.a_pos_y));
    aw = longint'(p.a_width); ah = longint'(p.a_height); ar = longint'(p.a_radius);
    bx = longint'($signed(p.b_pos_x)); by = longint'($signed(p.b_pos_y));
    bw = longint'(p.b_width); bh = longint'(p.b_height); br = longint'(p.b_radius);
    if (p.a_round && p.b_round) begin
      dx = bx - ax;
      dy = by - ay;
      dsq = dist_sq(dx, dy);
      if (dsq < 128'(ar + br) * 128'(ar + br)) begin
        c.hit = 1'b1;
        if (dsq == 0) begin
          c.nx = ONE_Q14;   // coincident centres
          c.dep = clip_depth(ar + br);
        end else begin
          s = root_q30(dsq);
          c.nx = unit_q14(dx, s);
          c.ny = unit_q14(dy, s);
          c.dep = clip_depth(ar + br - longint'(s >> 14));
        end
      end
    end else if (p.a_round) begin
      c = circle_vs_box(ax, ay, ar, bx, by, bw, bh);
    end else if (p.b_round) begin
      c = circle_vs_box(bx, by, br, ax, ay, aw, ah);
      c.nx = -c.nx;
      c.ny = -c.ny;
    end else if (!(ax + aw <= bx || bx + bw <= ax || ay + ah <= by || by + bh <= ay)) begin
      c.hit = 1'b1;
      ox = (ax + aw < bx + bw) ? ax + aw - bx : bx + bw - ax;
      oy = (ay + ah < by + bh) ? ay + ah - by : by + bh - ay;
      if (ox < oy) begin
        c.dep = clip_depth(ox);
        c.nx = (2 * ax + aw < 2 * bx + bw) ? ONE_Q14 : MONE_Q14;
      end else begin
        c.dep = clip_depth(oy);
        c.ny = (2 * ay + ah < 2 * by + bh) ? ONE_Q14 : MONE_Q14;
      end
    end
    return c;
  endfunction

  // ---------------- stimulus ----------------

  function automatic pair_t mk_pair(longint ax, longint ay, longint aw, longint ah,
                                    longint ar, bit ac, longint bx, longint by,
                                    longint bw, longint bh, longint br, bit bc);
    pair_t p;
    p.a_pos_x = PW'(ax); p.a_pos_y = PW'(ay); p.a_width = SW'(aw); p.a_height = SW'(ah);
    p.a_radius = SW'(ar); p.a_round = ac;
    p.b_pos_x = PW'(bx); p.b_pos_y = PW'(by); p.b_width = SW'(bw); p.b_height = SW'(bh);
    p.b_radius = SW'(br); p.b_round = bc;
    return p;
  endfunction

  task automatic add_row(pair_t p, bit typed, bit h = 0, int nx = 0, int ny = 0,
                         longint dep = 0);
    row_t r;
    r.p = p;
    r.typed = typed;
    r.e.hit = h; r.e.nx = 16'(nx); r.e.ny = 16'(ny); r.e.dep = 32'(dep);
    dir_rows.push_back(r);
  endtask

  function automatic longint rnd_coord(int sh);
    if ($urandom_range(0, 7) == 0) return longint'($signed($urandom()));
    return (longint'($urandom_range(0, 4096)) - 2048) <<< sh;
  endfunction

  function automatic longint rnd_size(int sh);
    case ($urandom_range(0, 9))
      0: return longint'($urandom() & 32'h7FFF_FFFF);
      1: return 0;
      default: return longint'($urandom_range(0, 3000)) << sh;
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    int sh;
    sh = $urandom_range(0, 16);
    p = mk_pair(rnd_coord(sh), rnd_coord(sh), rnd_size(sh), rnd_size(sh), rnd_size(sh),
                1'($urandom_range(0, 1)), rnd_coord(sh), rnd_coord(sh), rnd_size(sh),
                rnd_size(sh), rnd_size(sh), 1'($urandom_range(0, 1)));
    // mostly place B near A so contacts actually happen
    if ($urandom_range(0, 3) != 0) begin
      p.b_pos_x = PW'(longint'($signed(p.a_pos_x)) +
                      ((longint'($urandom_range(0, 2000)) - 1000) <<< sh));
      p.b_pos_y = PW'(longint'($signed(p.a_pos_y)) +
                      ((longint'($urandom_range(0, 2000)) - 1000) <<< sh));
    end
    return p;
  endfunction

  task automatic drive_pair(pair_t p);
    in_a_pos_x <= p.a_pos_x; in_a_pos_y <= p.a_pos_y;
    in_a_width <= p.a_width; in_a_height <= p.a_height;
    in_a_radius <= p.a_radius; in_a_round <= p.a_round;
    in_b_pos_x <= p.b_pos_x; in_b_pos_y <= p.b_pos_y;
    in_b_width <= p.b_width; in_b_height <= p.b_height;
    in_b_radius <= p.b_radius; in_b_round <= p.b_round;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    pairs_sent++;
  endtask

  // Bursts of random length with random gaps; no gaps while the receiver holds off
  int burst_left = 0;
  task automatic sender_gap();
    int gap;
    if (hold_req || pop_hold) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 30);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------- receiver ----------------

  int rx_cyc = 0;
  initial begin
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        pop_hold = 1'b1;
        out_pop <= 1'b0;
        for (int i = 0; i < HOLD_LEN; i++) @(posedge clk);
        pop_hold = 1'b0;
      end
      case ((rx_cyc / 97) % 4)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        2: out_pop <= ($urandom_range(0, 3) != 0);
        default: out_pop <= (rx_cyc % 5 < 2);
      endcase
    end
  end

  // Compare each popped contact with the oldest expectation
  always @(posedge clk) begin
    contact_t got, want;
    if (rst_n && out_pop && !out_empty) begin
      got = {out_hit, out_normal_x, out_normal_y, out_depth};
      contacts_seen++;
      if (out_hit) hits_seen++;
      if (contacts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected contact %p", got);
      end else begin
        want = contacts_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: contact %0d: hit %b/%b nx %0d/%0d ny %0d/%0d dep %h/%h (exp/act)",
                     contacts_seen, want.hit, got.hit, want.nx, got.nx, want.ny, got.ny,
                     want.dep, got.dep);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: watchdog, no transaction for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    // box/box: zero size, x axis, tie, equal centres, touching edges
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    add_row(mk_pair(0, 0, 10, 100, 0, 0, 8, 0, 10, 100, 0, 0), 1, 1, 16384, 0, 2);
    add_row(mk_pair(0, 0, 10, 10, 0, 0, 5, 5, 10, 10, 0, 0), 1, 1, 0, 16384, 5);
    add_row(mk_pair(0, 0, 10, 10, 0, 0, 0, 0, 10, 10, 0, 0), 1, 1, 0, -16384, 10);
    add_row(mk_pair(0, 0, 10, 10, 0, 0, 10, 0, 10, 10, 0, 0), 1);
    // circle/circle: coincident, zero radius, touching, plain overlap
    add_row(mk_pair(7, 7, 0, 0, 3, 1, 7, 7, 0, 0, 4, 1), 1, 1, 16384, 0, 7);
    add_row(mk_pair(7, 7, 0, 0, 0, 1, 7, 7, 0, 0, 0, 1), 1);
    add_row(mk_pair(0, 0, 0, 0, 5, 1, 10, 0, 0, 0, 5, 1), 1);
    add_row(mk_pair(0, 0, 0, 0, 40000, 1, 30000, -20000, 0, 0, 50000, 1), 0);
    // circle centre inside box, each face, then box-then-circle
    add_row(mk_pair(1, 5, 0, 0, 2, 1, 0, 0, 10, 10, 0, 0), 1, 1, 16384, 0, 3);
    add_row(mk_pair(9, 5, 0, 0, 2, 1, 0, 0, 10, 10, 0, 0), 1, 1, -16384, 0, 3);
    add_row(mk_pair(5, 1, 0, 0, 2, 1, 0, 0, 10, 10, 0, 0), 1, 1, 0, 16384, 3);
    add_row(mk_pair(5, 9, 0, 0, 2, 1, 0, 0, 10, 10, 0, 0), 1, 1, 0, -16384, 3);
    add_row(mk_pair(0, 0, 10, 10, 0, 0, 1, 5, 0, 0, 2, 1), 1, 1, -16384, 0, 3);
    // point box on the circle centre: all faces tie, left wins
    add_row(mk_pair(5, 5, 0, 0, 2, 1, 5, 5, 0, 0, 0, 0), 1, 1, 16384, 0, 2);
    add_row(mk_pair(-65536, -65536, 0, 0, 131072, 1, 0, 0, 65536, 65536, 0, 0), 0);
    add_row(mk_pair(0, 0, 65536, 65536, 0, 0, 90000, 80000, 0, 0, 30000, 1), 0);
    // extremes of every field
    add_row(mk_pair(-2147483648, -2147483648, 2147483647, 2147483647, 2147483647, 0,
                    -2147483648, -2147483648, 2147483647, 2147483647, 2147483647, 0), 0);
    add_row(mk_pair(-2147483648, -2147483648, 0, 0, 2147483647, 1,
                    2147483647, 2147483647, 0, 0, 2147483647, 1), 0);
    add_row(mk_pair(0, 0, 0, 0, 2147483647, 1, 0, 0, 0, 0, 2147483647, 1), 0);
    add_row(mk_pair(0, 0, 2147483647, 2147483647, 2147483647, 1,
                    -2147483648, -2147483648, 2147483647, 2147483647, 2147483647, 0), 0);
    add_row(mk_pair(2147483647, 2147483647, 2147483647, 2147483647, 2147483647, 0,
                    2147483647, 2147483647, 2147483647, 2147483647, 2147483647, 1), 0);
    add_row(mk_pair(-1, -1, 2147483647, 2147483647, 2147483647, 1,
                    -1, -1, 2147483647, 2147483647, 2147483647, 1), 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      drive_pair(dir_rows[i].p);
      contacts_due.push_back(dir_rows[i].typed ? dir_rows[i].e : predict_contact(dir_rows[i].p));
      sender_gap();
    end

    // let the directed part drain fully before random traffic
    in_push <= 1'b0;
    while (contacts_due.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      pair_t p;
      p = rnd_pair();
      if (n == N_RANDOM / 2) hold_req = 1'b1;   // back up the core until it stalls
      drive_pair(p);
      contacts_due.push_back(predict_contact(p));
      sender_gap();
    end
    in_push <= 1'b0;

    while (contacts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d pairs (directed and random), %0d contacts checked, %0d hits.",
             pairs_sent, contacts_seen, hits_seen);
    if (mismatches == 0 && contacts_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
